// ===== rtl/core/mso_pkg.sv =====
// merge sort block: shared constants, state codes and controller/datapath bundles
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mso_pkg;

	localparam int MAX_LEN     = 64;
	localparam int DATA_W      = 32;
	localparam int INV_W       = 11;
	localparam int CMP_W       = 9;
	localparam int IDX_W       = $clog2(MAX_LEN);
	localparam int CNT_W       = IDX_W + 1;
	localparam int STK_DEPTH   = IDX_W + 2;
	localparam int STK_IDX_W   = $clog2(STK_DEPTH);
	localparam int SP_W        = STK_IDX_W + 1;

	typedef enum logic [3:0] {
		S_LOAD,
		S_START,
		S_NODE,
		S_M_LA,
		S_M_LB,
		S_M_CMP,
		S_M_LD,
		S_CP,
		S_OUT_RD,
		S_OUT_LD,
		S_OUT
	} state_t;

	// progress of one range on the recursion stack
	typedef enum logic [1:0] {
		PH_LEFT,
		PH_RIGHT,
		PH_MERGE
	} phase_t;

	typedef struct packed {
		logic load;
		logic push_root;
		logic pop;
		logic desc_left;
		logic desc_right;
		logic merge_init;
		logic lat_a;
		logic lat_b;
		logic take;
		logic lat_sel;
		logic copy_start;
		logic copy;
		logic out_load;
		logic out_next;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic   stack_empty;
		logic   top_trivial;
		phase_t top_phase;
		logic   merge_done;
		logic   copy_last;
		logic   out_last;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mso_elem_if.sv =====
// input channel: one list element per beat
// uses mso_pkg for the data width
`timescale 1ns / 1ps
`default_nettype none

interface mso_elem_if;
	logic                               valid;
	logic                               ready;
	logic signed [mso_pkg::DATA_W-1:0]  value;
	logic                               last;

	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mso_result_if.sv =====
// output channel: one sorted element with totals per beat
// uses mso_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface mso_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [mso_pkg::DATA_W-1:0]  sorted_value;
	logic                               end_of_list;
	logic [mso_pkg::INV_W-1:0]          inversion_total;
	logic [mso_pkg::CMP_W-1:0]          comparison_total;
	logic                               overflow;

	modport source (output valid, sorted_value, end_of_list, inversion_total,
		comparison_total, overflow, input ready);
	modport sink (input valid, sorted_value, end_of_list, inversion_total,
		comparison_total, overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mso_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mso_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/mso_ctrl.sv =====
// sequencer for load, recursive split/merge walk and result emission
// uses mso_pkg state, command and status types
`timescale 1ns / 1ps
`default_nettype none

module mso_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              elem_valid,
	input  wire logic              elem_last,
	output logic                   elem_ready,
	output logic                   result_valid,
	input  wire logic              result_ready,
	input  wire mso_pkg::status_t  status,
	output mso_pkg::cmd_t          cmd
);

	mso_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mso_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mso_pkg::S_LOAD: begin
				if (elem_valid && elem_last) state_d = mso_pkg::S_START;
			end
			mso_pkg::S_START: state_d = mso_pkg::S_NODE;
			mso_pkg::S_NODE: begin
				if (status.stack_empty) begin
					state_d = mso_pkg::S_OUT_RD;
				end else if (!status.top_trivial && status.top_phase == mso_pkg::PH_MERGE) begin
					state_d = mso_pkg::S_M_LA;
				end
			end
			mso_pkg::S_M_LA: state_d = mso_pkg::S_M_LB;
			mso_pkg::S_M_LB: state_d = mso_pkg::S_M_CMP;
			mso_pkg::S_M_CMP: begin
				state_d = status.merge_done ? mso_pkg::S_CP : mso_pkg::S_M_LD;
			end
			mso_pkg::S_M_LD: state_d = mso_pkg::S_M_CMP;
			mso_pkg::S_CP: begin
				if (status.copy_last) state_d = mso_pkg::S_NODE;
			end
			mso_pkg::S_OUT_RD: state_d = mso_pkg::S_OUT_LD;
			mso_pkg::S_OUT_LD: state_d = mso_pkg::S_OUT;
			mso_pkg::S_OUT: begin
				if (result_ready) begin
					state_d = status.out_last ? mso_pkg::S_LOAD : mso_pkg::S_OUT_RD;
				end
			end
			default: state_d = mso_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		cmd          = '0;
		elem_ready   = 1'b0;
		result_valid = 1'b0;
		case (state_q)
			mso_pkg::S_LOAD: begin
				elem_ready = 1'b1;
				cmd.load   = elem_valid;
			end
			mso_pkg::S_START: cmd.push_root = 1'b1;
			mso_pkg::S_NODE: begin
				if (!status.stack_empty) begin
					if (status.top_trivial) begin
						cmd.pop = 1'b1;
					end else begin
						case (status.top_phase)
							mso_pkg::PH_LEFT:  cmd.desc_left = 1'b1;
							mso_pkg::PH_RIGHT: cmd.desc_right = 1'b1;
							default:           cmd.merge_init = 1'b1;
						endcase
					end
				end
			end
			mso_pkg::S_M_LA: cmd.lat_a = 1'b1;
			mso_pkg::S_M_LB: cmd.lat_b = 1'b1;
			mso_pkg::S_M_CMP: begin
				if (status.merge_done) begin
					cmd.copy_start = 1'b1;
				end else begin
					cmd.take = 1'b1;
				end
			end
			mso_pkg::S_M_LD: cmd.lat_sel = 1'b1;
			mso_pkg::S_CP: begin
				cmd.copy = 1'b1;
				cmd.pop  = status.copy_last;
			end
			mso_pkg::S_OUT_RD: ;
			mso_pkg::S_OUT_LD: cmd.out_load = 1'b1;
			mso_pkg::S_OUT: begin
				result_valid = 1'b1;
				if (result_ready) begin
					cmd.out_next = !status.out_last;
					cmd.finish   = status.out_last;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/mso_dp.sv =====
// datapath: element and scratch rams, range stack, merge pointers, totals, output register
// uses mso_pkg and mso_ram
`timescale 1ns / 1ps
`default_nettype none

module mso_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mso_pkg::cmd_t                       cmd,
	output mso_pkg::status_t                         status,
	input  wire logic signed [mso_pkg::DATA_W-1:0]   elem_value,
	output logic signed [mso_pkg::DATA_W-1:0]        sorted_value,
	output logic                                     end_of_list,
	output logic [mso_pkg::INV_W-1:0]                inversion_total,
	output logic [mso_pkg::CMP_W-1:0]                comparison_total,
	output logic                                     overflow
);

	localparam int IW = mso_pkg::IDX_W;
	localparam int CW = mso_pkg::CNT_W;

	// counts and totals
	logic [CW-1:0]             cnt_q;
	logic                      ovf_q;
	logic [mso_pkg::INV_W-1:0] inv_q;
	logic [mso_pkg::CMP_W-1:0] cmp_q;
	logic [CW-1:0]             k_q;

	// range stack
	logic [IW-1:0]             stk_lo_q [mso_pkg::STK_DEPTH];
	logic [IW-1:0]             stk_hi_q [mso_pkg::STK_DEPTH];
	mso_pkg::phase_t           stk_ph_q [mso_pkg::STK_DEPTH];
	logic [mso_pkg::SP_W-1:0]  sp_q;
	logic [mso_pkg::SP_W-1:0]  sp_dec;
	logic [mso_pkg::STK_IDX_W-1:0] top_idx, push_idx;
	logic [IW-1:0]             top_lo, top_hi, top_mid;
	logic [CW-1:0]             top_sum;

	// merge state
	logic [CW-1:0]             a_q, b_q, n_q, t_q;
	logic [IW-1:0]             lo_q, mid_q, hi_q;
	logic signed [mso_pkg::DATA_W-1:0] head_a_q, head_b_q;
	logic                      sel_b_q;
	logic                      a_ok, b_ok, take_a;
	logic [CW-1:0]             a_inc, b_inc, run_len, left_rem;

	// ram ports
	logic                      st_we, sc_we;
	logic [IW-1:0]             st_waddr, st_raddr, sc_raddr;
	logic [mso_pkg::DATA_W-1:0] st_wdata, st_rdata, sc_wdata, sc_rdata;
	logic                      full;

	mso_ram #(.WIDTH(mso_pkg::DATA_W), .DEPTH(mso_pkg::MAX_LEN)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	mso_ram #(.WIDTH(mso_pkg::DATA_W), .DEPTH(mso_pkg::MAX_LEN)) u_scratch (
		.clk   (clk),
		.we    (sc_we),
		.waddr (n_q[IW-1:0]),
		.wdata (sc_wdata),
		.raddr (sc_raddr),
		.rdata (sc_rdata)
	);

	assign full     = (cnt_q == CW'(mso_pkg::MAX_LEN));
	assign sp_dec   = sp_q - mso_pkg::SP_W'(1);
	assign top_idx  = sp_dec[mso_pkg::STK_IDX_W-1:0];
	assign push_idx = sp_q[mso_pkg::STK_IDX_W-1:0];
	assign top_lo   = stk_lo_q[top_idx];
	assign top_hi   = stk_hi_q[top_idx];
	assign top_sum  = {1'b0, top_lo} + {1'b0, top_hi};
	assign top_mid  = top_sum[CW-1:1];

	assign a_ok     = (a_q <= {1'b0, mid_q});
	assign b_ok     = (b_q <= {1'b0, hi_q});
	assign take_a   = a_ok && (!b_ok || (head_a_q <= head_b_q));
	assign a_inc    = a_q + CW'(1);
	assign b_inc    = b_q + CW'(1);
	assign left_rem = {1'b0, mid_q} - a_q + CW'(1);
	assign run_len  = {1'b0, hi_q} - {1'b0, lo_q};

	assign status.stack_empty = (sp_q == '0);
	assign status.top_trivial = (top_lo >= top_hi);
	assign status.top_phase   = stk_ph_q[top_idx];
	assign status.merge_done  = !a_ok && !b_ok;
	assign status.copy_last   = (t_q == run_len);
	assign status.out_last    = (k_q == cnt_q - CW'(1));

	// store ram: write from load or copy-back, read for merge heads or emission
	always_comb begin
		st_we    = 1'b0;
		st_waddr = cnt_q[IW-1:0];
		st_wdata = elem_value;
		if (cmd.load && !full) begin
			st_we = 1'b1;
		end else if (cmd.copy) begin
			st_we    = 1'b1;
			st_waddr = lo_q + t_q[IW-1:0];
			st_wdata = sc_rdata;
		end
	end

	always_comb begin
		st_raddr = k_q[IW-1:0];
		if (cmd.merge_init) begin
			st_raddr = top_lo;
		end else if (cmd.lat_a) begin
			st_raddr = b_q[IW-1:0];
		end else if (cmd.take) begin
			st_raddr = take_a ? a_inc[IW-1:0] : b_inc[IW-1:0];
		end
	end

	assign sc_we    = cmd.take;
	assign sc_wdata = take_a ? head_a_q : head_b_q;
	assign sc_raddr = cmd.copy ? (t_q[IW-1:0] + IW'(1)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			inv_q <= '0;
			cmp_q <= '0;
			k_q   <= '0;
			sp_q  <= '0;
		end else begin
			if (cmd.load) begin
				if (full) ovf_q <= 1'b1;
				else      cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.push_root) begin
				sp_q  <= mso_pkg::SP_W'(1);
				inv_q <= '0;
				cmp_q <= '0;
			end
			if (cmd.desc_left || cmd.desc_right) sp_q <= sp_q + mso_pkg::SP_W'(1);
			if (cmd.pop) sp_q <= sp_dec;
			if (cmd.take) begin
				if (a_ok && b_ok) cmp_q <= cmp_q + mso_pkg::CMP_W'(1);
				if (!take_a && a_ok) inv_q <= inv_q + mso_pkg::INV_W'(left_rem);
			end
			if (cmd.out_next) k_q <= k_q + CW'(1);
			if (cmd.finish) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				inv_q <= '0;
				cmp_q <= '0;
				k_q   <= '0;
			end
		end
	end

	// stack entries and merge payload
	always_ff @(posedge clk) begin
		if (cmd.push_root) begin
			stk_lo_q[0] <= '0;
			stk_hi_q[0] <= cnt_q[IW-1:0] - IW'(1);
			stk_ph_q[0] <= mso_pkg::PH_LEFT;
		end
		if (cmd.desc_left) begin
			stk_ph_q[top_idx]  <= mso_pkg::PH_RIGHT;
			stk_lo_q[push_idx] <= top_lo;
			stk_hi_q[push_idx] <= top_mid;
			stk_ph_q[push_idx] <= mso_pkg::PH_LEFT;
		end
		if (cmd.desc_right) begin
			stk_ph_q[top_idx]  <= mso_pkg::PH_MERGE;
			stk_lo_q[push_idx] <= top_mid + IW'(1);
			stk_hi_q[push_idx] <= top_hi;
			stk_ph_q[push_idx] <= mso_pkg::PH_LEFT;
		end
		if (cmd.merge_init) begin
			lo_q  <= top_lo;
			mid_q <= top_mid;
			hi_q  <= top_hi;
			a_q   <= {1'b0, top_lo};
			b_q   <= {1'b0, top_mid} + CW'(1);
			n_q   <= '0;
		end
		if (cmd.lat_a) head_a_q <= st_rdata;
		if (cmd.lat_b) head_b_q <= st_rdata;
		if (cmd.take) begin
			n_q     <= n_q + CW'(1);
			sel_b_q <= !take_a;
			if (take_a) a_q <= a_inc;
			else        b_q <= b_inc;
		end
		if (cmd.lat_sel) begin
			if (sel_b_q) head_b_q <= st_rdata;
			else         head_a_q <= st_rdata;
		end
		if (cmd.copy_start) t_q <= '0;
		if (cmd.copy)       t_q <= t_q + CW'(1);
		if (cmd.out_load) begin
			sorted_value     <= st_rdata;
			end_of_list      <= status.out_last;
			inversion_total  <= inv_q;
			comparison_total <= cmp_q;
			overflow         <= ovf_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/merge_sort_inversion_count.sv =====
// top level: merge sort with inversion and comparison totals
// uses mso_pkg, mso_elem_if, mso_result_if, mso_ctrl, mso_dp
//
//   channel  dir  payload                                              beat
//   elem     in   value[31:0] signed, last                             one list element
//   result   out  sorted_value, end_of_list, inversion_total,          one sorted element
//                 comparison_total, overflow
//
// loading accepts one element per cycle; elements beyond 64 are dropped and flagged.
// sorting walks the split tree with an eight-entry range stack; each merge moves every
// element through a compare state and a head-load state on the single read port of the
// element ram, then copies the merged run back from scratch.
// emission moves each element through read, load and output states, holding on result.ready.
// elem.ready is low from the closing beat until the final result beat is taken.
// arst_n clears the controller, counts and stack pointer; ram contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module merge_sort_inversion_count (
	input  wire logic      clk,
	input  wire logic      arst_n,
	mso_elem_if.sink       elem,
	mso_result_if.source   result
);

	mso_pkg::cmd_t    cmd;
	mso_pkg::status_t status;

	mso_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elem.valid),
		.elem_last    (elem.last),
		.elem_ready   (elem.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	mso_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.elem_value       (elem.value),
		.sorted_value     (result.sorted_value),
		.end_of_list      (result.end_of_list),
		.inversion_total  (result.inversion_total),
		.comparison_total (result.comparison_total),
		.overflow         (result.overflow)
	);

	// loading and emission never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(elem.ready && result.valid))
		else $error("input ready while result valid");

	// the closing beat stops further loading
	a_close_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		elem.valid && elem.ready && elem.last |=> !elem.ready)
		else $error("input still ready after closing beat");

	// after the final result beat the block returns to loading
	a_end_returns: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.end_of_list |=> !result.valid && elem.ready)
		else $error("no return to loading after final result");

endmodule

`default_nettype wire
